[hw/rtl/fmtp_pkg.sv]
// Shared types and constants for the FM tuner preset control block.
// No dependencies; imported by the core and the result stage.
package fmtp_pkg;

    localparam int SLOTS_DEFAULT  = 10;
    localparam int WORD_W         = 14;
    localparam int FREQ_W         = 18;
    localparam int SLOT_FIELD_W   = 4;
    localparam int ACT_W          = 4;
    localparam int CFG_INDEX_W    = 2;

    localparam logic [WORD_W-1:0] WORD_MIN_RESET = 14'd7018;
    localparam logic [WORD_W-1:0] WORD_MAX_RESET = 14'd8658;
    localparam logic [WORD_W-1:0] WORD_STEP      = 14'd8;
    localparam logic [WORD_W-1:0] WORD_SAT       = 14'h3FFF;

    // (w * 12500 - 225000) / 1000 equals (25 * w - 450) / 2 exactly,
    // and the subtraction goes negative below a word of 18.
    localparam logic [WORD_W-1:0] FREQ_MIN_WORD = 14'd18;
    localparam logic [WORD_W+4:0] FREQ_OFFSET   = 19'd450;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD     = 4'd0,
        ACT_RESTORE  = 4'd1,
        ACT_MUTE_ON  = 4'd2,
        ACT_MUTE_OFF = 4'd3,
        ACT_STBY_OFF = 4'd4,
        ACT_STBY_ON  = 4'd5,
        ACT_UP       = 4'd6,
        ACT_DOWN     = 4'd7,
        ACT_SAVE     = 4'd8,
        ACT_MODE     = 4'd9,
        ACT_NONE     = 4'd10
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WORD_MIN = 2'd0,
        CFG_WORD_MAX = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0]       tune_word;
        logic                    mute_on;
        logic                    standby_on;
        logic                    preset_mode;
        logic [SLOT_FIELD_W-1:0] current_slot;
        logic                    store_write;
    } result_t;

endpackage

[hw/rtl/fmtp_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the preset table.
module fmtp_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 10
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/fmtp_result.sv]
// Result register stage: converts the tune word to kHz and holds the word.
// Depends on fmtp_pkg.
module fmtp_result (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  fmtp_pkg::result_t                   in_result,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fmtp_pkg::WORD_W-1:0]         m_tune_word,
    output logic [fmtp_pkg::FREQ_W-1:0]         m_freq_khz,
    output logic                                m_mute_on,
    output logic                                m_standby_on,
    output logic                                m_preset_mode,
    output logic [fmtp_pkg::SLOT_FIELD_W-1:0]   m_current_slot,
    output logic                                m_store_write
);
    import fmtp_pkg::*;

    logic                 m_valid_reg;
    result_t              res_reg;
    logic [FREQ_W-1:0]    freq_reg;
    logic [WORD_W+4:0]    times25;
    logic [WORD_W+4:0]    diff;
    logic [FREQ_W-1:0]    freq_next;

    assign times25 = {in_result.tune_word, 5'b0} - {2'b0, in_result.tune_word, 3'b0}
                   + {5'b0, in_result.tune_word};
    assign diff = times25 - FREQ_OFFSET;

    always_comb begin
        if (in_result.tune_word < FREQ_MIN_WORD) begin
            freq_next = '0;
        end else begin
            freq_next = diff[FREQ_W:1];
        end
    end

    assign in_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            res_reg  <= in_result;
            freq_reg <= freq_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_tune_word    = res_reg.tune_word;
    assign m_freq_khz     = freq_reg;
    assign m_mute_on      = res_reg.mute_on;
    assign m_standby_on   = res_reg.standby_on;
    assign m_preset_mode  = res_reg.preset_mode;
    assign m_current_slot = res_reg.current_slot;
    assign m_store_write  = res_reg.store_write;

endmodule

[hw/rtl/fm_tuner_preset_control.sv]
// FM tuner preset control: one word per action, reporting word, kHz and flags.
// Flow: an accepted word starts its preset RAM read as it is taken, and is applied
// in the update state, where its result word is registered onto the output once
// the output stage is ready. A new word is taken only after the last one commits.
// Reset: flags, slot, word and limits return to their defaults and every table
// entry reads as zero through per-entry valid bits; no clearing pass is needed.
module fm_tuner_preset_control #(
    parameter int SLOTS = fmtp_pkg::SLOTS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fmtp_pkg::ACT_W-1:0]          s_action,
    input  logic [fmtp_pkg::SLOT_FIELD_W-1:0]   s_slot_number,
    input  logic [fmtp_pkg::WORD_W-1:0]         s_entry_word,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fmtp_pkg::WORD_W-1:0]         m_tune_word,
    output logic [fmtp_pkg::FREQ_W-1:0]         m_freq_khz,
    output logic                                m_mute_on,
    output logic                                m_standby_on,
    output logic                                m_preset_mode,
    output logic [fmtp_pkg::SLOT_FIELD_W-1:0]   m_current_slot,
    output logic                                m_store_write,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fmtp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fmtp_pkg::WORD_W-1:0]         cfg_data
);
    import fmtp_pkg::*;

    localparam int ADDR_W = $clog2(SLOTS);
    localparam logic [SLOT_FIELD_W:0]   SLOTS_V   = (SLOT_FIELD_W+1)'(SLOTS);
    localparam logic [SLOT_FIELD_W-1:0] SLOT_LAST = SLOT_FIELD_W'(SLOTS - 1);

    state_t                  state_reg, state_next;
    action_t                 act_reg;
    logic [SLOT_FIELD_W-1:0] slot_in_reg;
    logic [WORD_W-1:0]       entry_reg;
    logic [SLOT_FIELD_W-1:0] rd_slot_reg, rd_slot;
    logic                    rd_valid_reg;

    logic [SLOT_FIELD_W-1:0] slot_reg, slot_next;
    logic [WORD_W-1:0]       word_reg, word_next;
    logic                    preset_reg, preset_next;
    logic                    mute_reg, mute_next;
    logic                    standby_reg, standby_next;
    logic [WORD_W-1:0]       min_reg, max_reg;
    logic [SLOTS-1:0]        valid_reg;

    logic                    accept, commit;
    logic [SLOT_FIELD_W:0]   slot_inc;
    logic [WORD_W:0]         word_sum;
    logic [WORD_W-1:0]       ram_rdata, table_word;
    logic                    wr_en;
    logic [SLOT_FIELD_W-1:0] wr_slot;
    logic [WORD_W-1:0]       wr_data;
    logic                    store_next;
    logic                    out_ready;
    result_t                 result;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign commit    = (state_reg == ST_UPDATE) && out_ready;
    assign cfg_ready = 1'b1;

    // Table slot the action will need, read while the word is accepted.
    assign slot_inc = {1'b0, slot_reg} + (SLOT_FIELD_W+1)'(1);
    always_comb begin
        rd_slot = '0;
        case (s_action)
            ACT_RESTORE: rd_slot = ({1'b0, s_slot_number} < SLOTS_V) ? s_slot_number : '0;
            ACT_UP:      rd_slot = (slot_inc < SLOTS_V) ? slot_inc[SLOT_FIELD_W-1:0] : SLOT_LAST;
            ACT_DOWN:    rd_slot = (slot_reg != '0) ? slot_reg - SLOT_FIELD_W'(1) : slot_reg;
            default:     rd_slot = '0;
        endcase
    end

    always_comb begin
        unique case (state_reg)
            ST_IDLE:   state_next = accept ? ST_UPDATE : ST_IDLE;
            ST_UPDATE: state_next = commit ? ST_IDLE : ST_UPDATE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Entries never written read as zero.
    assign table_word = rd_valid_reg ? ram_rdata : '0;
    assign word_sum   = {1'b0, word_reg} + {1'b0, WORD_STEP};

    always_comb begin
        slot_next    = slot_reg;
        word_next    = word_reg;
        preset_next  = preset_reg;
        mute_next    = mute_reg;
        standby_next = standby_reg;
        wr_en        = 1'b0;
        wr_slot      = slot_reg;
        wr_data      = word_reg;
        store_next   = 1'b0;
        unique case (act_reg)
            ACT_LOAD: begin
                wr_slot = slot_in_reg;
                wr_data = entry_reg;
                wr_en   = ({1'b0, slot_in_reg} < SLOTS_V);
            end
            ACT_STBY_OFF: standby_next = 1'b0;
            ACT_STBY_ON:  standby_next = 1'b1;
            ACT_RESTORE: begin
                if (!standby_reg) begin
                    slot_next   = rd_slot_reg;
                    preset_next = 1'b1;
                    mute_next   = 1'b0;
                    word_next   = table_word;
                end
            end
            ACT_MUTE_ON:  if (!standby_reg) mute_next = 1'b1;
            ACT_MUTE_OFF: if (!standby_reg) mute_next = 1'b0;
            ACT_UP: begin
                if (!standby_reg) begin
                    if (preset_reg) begin
                        slot_next = rd_slot_reg;
                        word_next = table_word;
                    end else if (word_reg < max_reg) begin
                        word_next = word_sum[WORD_W] ? WORD_SAT : word_sum[WORD_W-1:0];
                    end
                end
            end
            ACT_DOWN: begin
                if (!standby_reg) begin
                    if (preset_reg) begin
                        slot_next = rd_slot_reg;
                        word_next = table_word;
                    end else if (word_reg > min_reg) begin
                        word_next = (word_reg >= WORD_STEP) ? word_reg - WORD_STEP : '0;
                    end
                end
            end
            ACT_SAVE: begin
                if (!standby_reg) begin
                    preset_next = 1'b1;
                    wr_en       = 1'b1;
                    store_next  = 1'b1;
                end
            end
            ACT_MODE: begin
                if (!standby_reg) begin
                    preset_next = !preset_reg;
                    if (!preset_reg) begin
                        slot_next = rd_slot_reg;
                        word_next = table_word;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slot_reg    <= '0;
            word_reg    <= '0;
            preset_reg  <= 1'b1;
            mute_reg    <= 1'b0;
            standby_reg <= 1'b0;
            valid_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                slot_reg    <= slot_next;
                word_reg    <= word_next;
                preset_reg  <= preset_next;
                mute_reg    <= mute_next;
                standby_reg <= standby_next;
                if (wr_en) begin
                    valid_reg[wr_slot[ADDR_W-1:0]] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= WORD_MIN_RESET;
            max_reg <= WORD_MAX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WORD_MIN: min_reg <= cfg_data;
                CFG_WORD_MAX: max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg      <= action_t'(s_action);
            slot_in_reg  <= s_slot_number;
            entry_reg    <= s_entry_word;
            rd_slot_reg  <= rd_slot;
            rd_valid_reg <= valid_reg[rd_slot[ADDR_W-1:0]];
        end
    end

    fmtp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (commit && wr_en),
        .waddr (wr_slot[ADDR_W-1:0]),
        .wdata (wr_data),
        .re    (accept),
        .raddr (rd_slot[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign result.tune_word    = word_next;
    assign result.mute_on      = mute_next;
    assign result.standby_on   = standby_next;
    assign result.preset_mode  = preset_next;
    assign result.current_slot = slot_next;
    assign result.store_write  = store_next;

    fmtp_result u_result (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (state_reg == ST_UPDATE),
        .in_ready       (out_ready),
        .in_result      (result),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_tune_word    (m_tune_word),
        .m_freq_khz     (m_freq_khz),
        .m_mute_on      (m_mute_on),
        .m_standby_on   (m_standby_on),
        .m_preset_mode  (m_preset_mode),
        .m_current_slot (m_current_slot),
        .m_store_write  (m_store_write)
    );

    a_accept_update: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_UPDATE))
        else $error("accepted word did not enter the update cycle");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, slot_reg} < SLOTS_V))
        else $error("current slot outside the table");

    a_store_save: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && store_next) |-> (act_reg == ACT_SAVE && !standby_reg))
        else $error("store flagged for an action other than save");

    a_write_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && wr_en) |=> valid_reg[$past(wr_slot[ADDR_W-1:0])])
        else $error("table write did not mark its entry valid");

endmodule
